/* rtl/core/assert_macros.svh */
// Assertion helpers, clocked on clk with active-low rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is held off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that is evaluated during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/mpk_enc_pkg.sv */
`default_nettype none

package mpk_enc_pkg;

    localparam int ByteW   = 8;
    localparam int ValueW  = 64;
    localparam int MaxBytes = 9;
    localparam int BufW    = ByteW * MaxBytes;
    localparam int CntW    = 4;

    typedef enum logic [3:0] {
        MODE_UINT  = 4'd0,
        MODE_SINT  = 4'd1,
        MODE_BOOL  = 4'd2,
        MODE_NIL   = 4'd3,
        MODE_F32   = 4'd4,
        MODE_F64   = 4'd5,
        MODE_STR   = 4'd6,
        MODE_BIN   = 4'd7,
        MODE_ARRAY = 4'd8,
        MODE_MAP   = 4'd9,
        MODE_RAW   = 4'd10
    } mode_t;

    localparam logic [7:0] TAG_FIXMAP   = 8'h80;
    localparam logic [7:0] TAG_FIXARRAY = 8'h90;
    localparam logic [7:0] TAG_FIXSTR   = 8'ha0;
    localparam logic [7:0] TAG_NIL      = 8'hc0;
    localparam logic [7:0] TAG_FALSE    = 8'hc2;
    localparam logic [7:0] TAG_TRUE     = 8'hc3;
    localparam logic [7:0] TAG_BIN8     = 8'hc4;
    localparam logic [7:0] TAG_BIN16    = 8'hc5;
    localparam logic [7:0] TAG_BIN32    = 8'hc6;
    localparam logic [7:0] TAG_F32      = 8'hca;
    localparam logic [7:0] TAG_F64      = 8'hcb;
    localparam logic [7:0] TAG_U8       = 8'hcc;
    localparam logic [7:0] TAG_U16      = 8'hcd;
    localparam logic [7:0] TAG_U32      = 8'hce;
    localparam logic [7:0] TAG_U64      = 8'hcf;
    localparam logic [7:0] TAG_I8       = 8'hd0;
    localparam logic [7:0] TAG_I16      = 8'hd1;
    localparam logic [7:0] TAG_I32      = 8'hd2;
    localparam logic [7:0] TAG_I64      = 8'hd3;
    localparam logic [7:0] TAG_STR8     = 8'hd9;
    localparam logic [7:0] TAG_STR16    = 8'hda;
    localparam logic [7:0] TAG_STR32    = 8'hdb;
    localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
    localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
    localparam logic [7:0] TAG_MAP16    = 8'hde;
    localparam logic [7:0] TAG_MAP32    = 8'hdf;
    localparam logic [7:0] TAG_NEGFIX   = 8'he0;

    typedef struct packed {
        logic              valid;
        logic [BufW-1:0]   bytes;   // first byte in the top bits
        logic [CntW-1:0]   cnt;
    } enc_t;

    // head byte followed by the low nb bytes of v, big-endian, left aligned
    function automatic enc_t pack_item(logic [7:0] head, logic [ValueW-1:0] v,
                                       logic [CntW-1:0] nb);
        enc_t e;
        e.valid = 1'b1;
        e.cnt   = nb + 4'd1;
        unique case (nb)
            4'd1:    e.bytes = {head, v[7:0],  56'd0};
            4'd2:    e.bytes = {head, v[15:0], 48'd0};
            4'd4:    e.bytes = {head, v[31:0], 32'd0};
            4'd8:    e.bytes = {head, v};
            default: e.bytes = {head, 64'd0};
        endcase
        return e;
    endfunction

    function automatic enc_t enc_unsigned(logic [ValueW-1:0] v);
        enc_t e;
        priority if (v[63:7] == '0)  e = pack_item(v[7:0], v, 4'd0);
        else if (v[63:8] == '0)      e = pack_item(TAG_U8, v, 4'd1);
        else if (v[63:16] == '0)     e = pack_item(TAG_U16, v, 4'd2);
        else if (v[63:32] == '0)     e = pack_item(TAG_U32, v, 4'd4);
        else                         e = pack_item(TAG_U64, v, 4'd8);
        return e;
    endfunction

    function automatic enc_t enc_signed(logic [ValueW-1:0] v);
        enc_t e;
        priority if (!v[63])                    e = enc_unsigned(v);
        else if (&v[63:5] && v[4:0] != '0)      e = pack_item(TAG_NEGFIX | {3'd0, v[4:0]},
                                                              v, 4'd0);
        else if (&v[63:7] && v[6:0] != '0)      e = pack_item(TAG_I8, v, 4'd1);
        else if (&v[63:15] && v[14:0] != '0)    e = pack_item(TAG_I16, v, 4'd2);
        else if (&v[63:31] && v[30:0] != '0)    e = pack_item(TAG_I32, v, 4'd4);
        else                                    e = pack_item(TAG_I64, v, 4'd8);
        return e;
    endfunction

    function automatic enc_t encode(logic [3:0] mode, logic [ValueW-1:0] v);
        enc_t e;
        e = '0;
        unique case (mode)
            MODE_UINT: e = enc_unsigned(v);
            MODE_SINT: e = enc_signed(v);
            MODE_BOOL: e = pack_item(v[0] ? TAG_TRUE : TAG_FALSE, v, 4'd0);
            MODE_NIL:  e = pack_item(TAG_NIL, v, 4'd0);
            MODE_F32:  e = pack_item(TAG_F32, v, 4'd4);
            MODE_F64:  e = pack_item(TAG_F64, v, 4'd8);
            MODE_STR: begin
                priority if (v[63:5] == '0)  e = pack_item(TAG_FIXSTR | {3'd0, v[4:0]},
                                                           v, 4'd0);
                else if (v[63:8] == '0)      e = pack_item(TAG_STR8, v, 4'd1);
                else if (v[63:16] == '0)     e = pack_item(TAG_STR16, v, 4'd2);
                else                         e = pack_item(TAG_STR32, v, 4'd4);
            end
            MODE_BIN: begin
                priority if (v[63:8] == '0)  e = pack_item(TAG_BIN8, v, 4'd1);
                else if (v[63:16] == '0)     e = pack_item(TAG_BIN16, v, 4'd2);
                else                         e = pack_item(TAG_BIN32, v, 4'd4);
            end
            MODE_ARRAY: begin
                priority if (v[63:4] == '0)  e = pack_item(TAG_FIXARRAY | {4'd0, v[3:0]},
                                                           v, 4'd0);
                else if (v[63:16] == '0)     e = pack_item(TAG_ARRAY16, v, 4'd2);
                else                         e = pack_item(TAG_ARRAY32, v, 4'd4);
            end
            MODE_MAP: begin
                priority if (v[63:4] == '0)  e = pack_item(TAG_FIXMAP | {4'd0, v[3:0]},
                                                           v, 4'd0);
                else if (v[63:16] == '0)     e = pack_item(TAG_MAP16, v, 4'd2);
                else                         e = pack_item(TAG_MAP32, v, 4'd4);
            end
            MODE_RAW:  e = pack_item(v[7:0], v, 4'd0);
            default:   e = '0;  // unused mode codes: no output
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/msgpack_scalar_header_encoder_core.sv */
// Channel  Dir  Beat contents
// -------  ---  -----------------------------------------------------
// s_*      in   one item: mode, value
// m_*      out  one encoded byte, tlast on the final byte of the item
//
// One output byte per cycle while m_tready is high; an item occupies the output for
// its encoded length of 1 to 9 bytes, held in the byte serializer register.
// An accepted item passes the encoded-item register, then the byte serializer register.
// A second item is held in an encoded-item register while the serializer runs.
// Unused mode codes are accepted and produce no bytes.
// rst_n clears both valid flags; a stalled byte holds until taken.
`default_nettype none

module msgpack_scalar_header_encoder_core
    import mpk_enc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,    // [3:0] mode, [67:4] value, [71:68] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] out_byte
    output logic             m_tlast
);

    enc_t            enc;
    logic            in_fire;
    logic            out_fire;
    logic            load_act;

    logic            pend_valid_reg, pend_valid_next;
    logic [BufW-1:0] pend_data_reg,  pend_data_next;
    logic [CntW-1:0] pend_cnt_reg,   pend_cnt_next;

    logic            act_valid_reg,  act_valid_next;
    logic [BufW-1:0] act_data_reg,   act_data_next;
    logic [CntW-1:0] act_cnt_reg,    act_cnt_next;

    assign enc      = encode(s_tdata[3:0], s_tdata[67:4]);
    assign m_tvalid = act_valid_reg;
    assign m_tdata  = act_data_reg[BufW-1 -: ByteW];
    assign m_tlast  = (act_cnt_reg == 4'd1);
    assign out_fire = m_tvalid && m_tready;
    assign load_act = pend_valid_reg && (!act_valid_reg || (out_fire && m_tlast));
    assign s_tready = !pend_valid_reg || load_act;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        pend_cnt_next   = pend_cnt_reg;
        if (load_act)
        begin
            pend_valid_next = 1'b0;
        end
        if (in_fire && enc.valid)
        begin
            pend_valid_next = 1'b1;
            pend_data_next  = enc.bytes;
            pend_cnt_next   = enc.cnt;
        end
    end

    always_comb
    begin
        act_valid_next = act_valid_reg;
        act_data_next  = act_data_reg;
        act_cnt_next   = act_cnt_reg;
        if (out_fire)
        begin
            act_data_next = {act_data_reg[BufW-ByteW-1:0], {ByteW{1'b0}}};
            act_cnt_next  = act_cnt_reg - 4'd1;
            if (m_tlast)
            begin
                act_valid_next = 1'b0;
            end
        end
        if (load_act)
        begin
            act_valid_next = 1'b1;
            act_data_next  = pend_data_reg;
            act_cnt_next   = pend_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            act_cnt_reg    <= '0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            act_valid_reg  <= act_valid_next;
            act_cnt_reg    <= act_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_data_reg <= pend_data_next;
        pend_cnt_reg  <= pend_cnt_next;
        act_data_reg  <= act_data_next;
    end

`include "assert_macros.svh"

    `ASSERT_CLK(a_act_cnt_range,
        act_valid_reg |-> (act_cnt_reg != 4'd0 && act_cnt_reg <= 4'd9),
        "active byte count out of range")
    `ASSERT_CLK(a_mid_item_continues,
        (out_fire && !m_tlast) |=> (act_valid_reg && act_cnt_reg == $past(act_cnt_reg) - 4'd1),
        "item run broken before last byte")
    `ASSERT_CLK(a_pend_holds,
        (pend_valid_reg && !load_act) |=> (pend_valid_reg && $stable(pend_data_reg)),
        "pending item lost or changed")
    `ASSERT_ALWAYS(a_ready_when_empty,
        !pend_valid_reg |-> s_tready,
        "input not ready with empty pending register")

endmodule

`default_nettype wire

/* tb/msgpack_scalar_header_encoder_core_test.sv */
module msgpack_scalar_header_encoder_core_test
    import mpk_enc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF        = 4;
    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          HOLD_CYCLES     = 300;
    localparam int          TAIL_CYCLES     = 20;
    localparam int          MAX_PRINTED     = 40;
    localparam logic [3:0]  MODE_UNUSED_LO  = 4'd11;
    localparam logic [3:0]  MODE_UNUSED_HI  = 4'd15;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;      // [3:0] mode, [67:4] value, [71:68] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] out_byte
    logic        m_tlast;

    enc_byte_t   pending_bytes[$];
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        rx_hold = 1'b0;
    int          errors = 0;
    int          items_sent = 0;
    int          bytes_checked = 0;
    int          stall_cycles = 0;
    int          cycle_count = 0;
    logic [15:0] modes_seen = '0;

    msgpack_scalar_header_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic int unsigned_form(input logic [63:0] v, output logic [7:0] head);
        if (v <= 64'h7f)
        begin
            head = v[7:0];
            return 0;
        end
        else if (v <= 64'hff)
        begin
            head = TAG_U8;
            return 1;
        end
        else if (v <= 64'hffff)
        begin
            head = TAG_U16;
            return 2;
        end
        else if (v <= 64'hffff_ffff)
        begin
            head = TAG_U32;
            return 4;
        end
        head = TAG_U64;
        return 8;
    endfunction

    // expected byte run of one item; unused modes give none
    function automatic void predict_item(input logic [3:0] mode, input logic [63:0] v);
        logic [7:0]  head;
        logic [63:0] mag;
        int          nb;
        head = 8'h00;
        nb   = -1;
        mag  = ~v + 64'd1;
        case (mode)
            MODE_UINT: nb = unsigned_form(v, head);
            MODE_SINT:
            begin
                if (!v[63])
                    nb = unsigned_form(v, head);
                else if (mag <= 64'h1f)
                begin
                    head = TAG_NEGFIX | {3'b000, v[4:0]};
                    nb = 0;
                end
                else if (mag <= 64'h7f)
                begin
                    head = TAG_I8;
                    nb = 1;
                end
                else if (mag <= 64'h7fff)
                begin
                    head = TAG_I16;
                    nb = 2;
                end
                else if (mag <= 64'h7fff_ffff)
                begin
                    head = TAG_I32;
                    nb = 4;
                end
                else
                begin
                    head = TAG_I64;
                    nb = 8;
                end
            end
            MODE_BOOL:
            begin
                head = v[0] ? TAG_TRUE : TAG_FALSE;
                nb = 0;
            end
            MODE_NIL:
            begin
                head = TAG_NIL;
                nb = 0;
            end
            MODE_F32:
            begin
                head = TAG_F32;
                nb = 4;
            end
            MODE_F64:
            begin
                head = TAG_F64;
                nb = 8;
            end
            MODE_STR:
            begin
                if (v <= 64'h1f)
                begin
                    head = TAG_FIXSTR | {3'b000, v[4:0]};
                    nb = 0;
                end
                else if (v <= 64'hff)
                begin
                    head = TAG_STR8;
                    nb = 1;
                end
                else if (v <= 64'hffff)
                begin
                    head = TAG_STR16;
                    nb = 2;
                end
                else
                begin
                    head = TAG_STR32;
                    nb = 4;
                end
            end
            MODE_BIN:
            begin
                if (v <= 64'hff)
                begin
                    head = TAG_BIN8;
                    nb = 1;
                end
                else if (v <= 64'hffff)
                begin
                    head = TAG_BIN16;
                    nb = 2;
                end
                else
                begin
                    head = TAG_BIN32;
                    nb = 4;
                end
            end
            MODE_ARRAY:
            begin
                if (v <= 64'hf)
                begin
                    head = TAG_FIXARRAY | {4'b0000, v[3:0]};
                    nb = 0;
                end
                else if (v <= 64'hffff)
                begin
                    head = TAG_ARRAY16;
                    nb = 2;
                end
                else
                begin
                    head = TAG_ARRAY32;
                    nb = 4;
                end
            end
            MODE_MAP:
            begin
                if (v <= 64'hf)
                begin
                    head = TAG_FIXMAP | {4'b0000, v[3:0]};
                    nb = 0;
                end
                else if (v <= 64'hffff)
                begin
                    head = TAG_MAP16;
                    nb = 2;
                end
                else
                begin
                    head = TAG_MAP32;
                    nb = 4;
                end
            end
            MODE_RAW:
            begin
                head = v[7:0];
                nb = 0;
            end
            default: nb = -1;
        endcase
        if (nb >= 0)
        begin
            pending_bytes.push_back('{head, nb == 0});
            for (int i = nb - 1; i >= 0; i--)
                pending_bytes.push_back('{v[i*8 +: 8], i == 0});
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
    endtask

    task automatic send_item(input logic [3:0] mode, input logic [63:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, v, mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(mode, v);
        items_sent++;
        modes_seen[mode] = 1'b1;
    endtask

    function automatic logic [63:0] threshold_at(input int idx);
        case (idx)
            0:       return 64'hf;
            1:       return 64'h1f;
            2:       return 64'h7f;
            3:       return 64'hff;
            4:       return 64'h7fff;
            5:       return 64'hffff;
            6:       return 64'h7fff_ffff;
            default: return 64'hffff_ffff;
        endcase
    endfunction

    task automatic send_random_items(input int count);
        logic [3:0]  mode;
        logic [63:0] v;
        int          sel;
        repeat (count)
        begin
            if ($urandom_range(0, 19) == 0)
                mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            else
                mode = 4'($urandom_range(MODE_UINT, MODE_RAW));
            v = {$urandom, $urandom};
            sel = $urandom_range(0, 9);
            if (sel < 4)
                v = v >> $urandom_range(0, 63);
            else if (sel < 7)
                v = threshold_at($urandom_range(0, 7)) + 64'($urandom_range(0, 2)) - 64'd1;
            if (mode == MODE_SINT && $urandom_range(0, 1) == 1)
                v = -v;
            send_item(mode, v);
        end
    endtask

    task automatic test_directed_cases;
        send_item(MODE_UINT, 64'h7f);
        send_item(MODE_UINT, 64'h80);
        send_item(MODE_UINT, 64'hffff_ffff);
        send_item(MODE_UINT, '1);
        send_item(MODE_SINT, -64'sd1);
        send_item(MODE_SINT, -64'sd31);
        send_item(MODE_SINT, -64'sd32);       // just past negative fixint
        send_item(MODE_SINT, -64'sd128);      // just past int8
        send_item(MODE_SINT, 64'h8000_0000_0000_0000);
        send_item(MODE_SINT, 64'h7fff_ffff_ffff_ffff);
        send_item(MODE_BOOL, 64'hffff_ffff_ffff_fffe);
        send_item(MODE_BOOL, 64'h1);
        send_item(MODE_NIL, '1);
        send_item(MODE_F32, 64'hdead_beef_3f80_0000);
        send_item(MODE_F64, 64'h0123_4567_89ab_cdef);
        send_item(MODE_STR, 64'd31);
        send_item(MODE_STR, 64'd32);
        send_item(MODE_STR, 64'h1_0000_0005);    // oversized length wraps
        send_item(MODE_BIN, 64'd0);
        send_item(MODE_BIN, 64'h1_0000);
        send_item(MODE_ARRAY, 64'd15);
        send_item(MODE_ARRAY, 64'd16);
        send_item(MODE_MAP, 64'hffff);
        send_item(MODE_MAP, '1);
        send_item(MODE_RAW, 64'hffff_ffff_ffff_ff80);
        send_item(MODE_UNUSED_HI, '1);
    endtask

    task automatic test_slow_sink;
        tx_idle_pct = 34;
        rx_idle_pct = 80;
        send_random_items(100);
    endtask

    task automatic test_slow_source;
        tx_idle_pct = 80;
        rx_idle_pct = 34;
        send_random_items(100);
    endtask

    task automatic test_full_rate;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_items(64);
    endtask

    task automatic test_backpressure;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            send_random_items(20);
        join
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        enc_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch("unexpected byte", m_tdata, 8'h00);
            else
            begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (m_tdata !== want.data)
                    report_mismatch("byte", m_tdata, want.data);
                if (m_tlast !== want.last)
                    report_mismatch("tlast", {7'b0, m_tlast}, {7'b0, want.last});
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && s_tvalid && !s_tready)
            stall_cycles++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, pending_bytes.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases;
        test_slow_sink;
        test_slow_source;
        test_backpressure;
        test_full_rate;

        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("encoded %0d items over %0d mode codes, %0d bytes checked",
                 items_sent, $countones(modes_seen), bytes_checked);
        $display("input stalled %0d cycles under output backpressure", stall_cycles);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mpk_enc_pkg.sv
rtl/core/msgpack_scalar_header_encoder_core.sv
tb/msgpack_scalar_header_encoder_core_test.sv
